// File: rtl/shs_pkg.sv
package shs_pkg;

	// Calibration rounds over which the slot period is averaged (1 to 7)
	localparam int unsigned CAL_ROUNDS = 3;

	localparam int unsigned ROUND_W   = 3;
	localparam int unsigned REV_W     = 16;
	localparam int unsigned EIGHTHS_W = 16;
	localparam int unsigned PROD_W    = REV_W + EIGHTHS_W;
	localparam int unsigned LEFT_W    = PROD_W - 3;

	localparam logic [ROUND_W-1:0] CAL_LAST   = ROUND_W'(CAL_ROUNDS - 1);
	localparam logic [ROUND_W:0]   CAL_ROUNDS_C = (ROUND_W + 1)'(CAL_ROUNDS);
	localparam logic [REV_W-1:0]   REV_MAX    = {REV_W{1'b1}};

	typedef enum logic [1:0] {
		OP_TICK = 2'd0,
		OP_CAL  = 2'd1,
		OP_RUN  = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_CAL  = 2'd1,
		MODE_RUN  = 2'd2
	} mode_t;

	// Calibration substates: seek past the slot, then count low/high halves
	typedef enum logic [1:0] {
		PH_SEEK_LOW  = 2'd0,
		PH_SEEK_HIGH = 2'd1,
		PH_CNT_LOW   = 2'd2,
		PH_CNT_HIGH  = 2'd3
	} cal_phase_t;

	typedef struct packed {
		logic [1:0]           op;
		logic                 opto_level;
		logic [EIGHTHS_W-1:0] run_eighths;
	} cmd_t;

	typedef struct packed {
		logic [3:0]       coils;
		logic             stepped;
		logic [1:0]       mode;
		logic [REV_W-1:0] steps_per_rev;
		logic             calibrated;
		logic             not_calibrated_error;
		logic             finished;
	} res_t;

	// Eight-pattern half-step sequence
	function automatic logic [3:0] half_step(input logic [2:0] idx);
		logic [3:0] pat;
		case (idx)
			3'd0: pat = 4'd1;
			3'd1: pat = 4'd3;
			3'd2: pat = 4'd2;
			3'd3: pat = 4'd6;
			3'd4: pat = 4'd4;
			3'd5: pat = 4'd12;
			3'd6: pat = 4'd8;
			3'd7: pat = 4'd9;
			default: pat = 4'd0;
		endcase
		return pat;
	endfunction

endpackage

// File: rtl/stepper_half_step_calibrated_run.sv
// Half-step stepper driver with opto-fork calibration and measured runs.
// Each item passes through the input register, then the result register.
// Throughput: one item per cycle while the receiver holds res_ready high, set
// by the single pass of the control logic between the two registers.
// Reset (arst_n low, asynchronous): idle, uncalibrated, coils off, both
// register stages empty.
module stepper_half_step_calibrated_run (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  shs_pkg::cmd_t cmd,
	output logic          res_valid,
	input  logic          res_ready,
	output shs_pkg::res_t res
);

	logic          item_vld_s1;
	shs_pkg::cmd_t item_s1;
	logic          res_vld_s2;
	shs_pkg::res_t res_s2;
	shs_pkg::res_t result;
	logic          advance;

	// s1 moves on when the result register is free or being emptied
	assign advance   = item_vld_s1 && (!res_vld_s2 || res_ready);
	assign cmd_ready = !item_vld_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_vld_s1 <= 1'b0;
		end else if (cmd_ready) begin
			item_vld_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready) begin
			item_s1 <= cmd;
		end
	end

	shs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (advance),
		.item   (item_s1),
		.result (result)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_s2 <= 1'b0;
		end else if (advance) begin
			res_vld_s2 <= 1'b1;
		end else if (res_ready) begin
			res_vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= result;
		end
	end

	assign res_valid = res_vld_s2;
	assign res       = res_s2;

`ifndef SYNTHESIS
	// a command item never drives a step
	a_cmd_no_step: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_s1.op != shs_pkg::OP_TICK |=> !res_s2.stepped)
		else $error("command item drove a step");

	// the error only comes from an uncalibrated, idle block
	a_err_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_vld_s2 && res_s2.not_calibrated_error |->
			!res_s2.calibrated && res_s2.mode == shs_pkg::MODE_IDLE)
		else $error("error flagged while calibrated or busy");

	// a step leaves the block busy unless it ends the run
	a_step_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_vld_s2 && res_s2.stepped |->
			res_s2.mode != shs_pkg::MODE_IDLE || res_s2.finished)
		else $error("step reported in idle without finish");

	// an empty input stage always takes an item
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!item_vld_s1 |-> cmd_ready)
		else $error("empty input stage refused an item");
`endif

endmodule

// File: rtl/shs_ctrl.sv
module shs_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          go,
	input  shs_pkg::cmd_t item,
	output shs_pkg::res_t result
);

	shs_pkg::mode_t      mode_q, mode_d;
	shs_pkg::cal_phase_t phase_q, phase_d;
	logic [shs_pkg::ROUND_W-1:0] round_q, round_d;
	// step tally kept as quotient and remainder by CAL_ROUNDS
	logic [shs_pkg::REV_W-1:0]   quot_q, quot_d;
	logic [shs_pkg::ROUND_W-1:0] rem_q, rem_d;
	logic [shs_pkg::REV_W-1:0]   rev_q, rev_d;
	logic [2:0]                  coil_phase_q, coil_phase_d;
	logic [shs_pkg::LEFT_W-1:0]  left_q, left_d;
	logic [3:0]                  coil_q, coil_d;

	logic                        step_en, count_en, stepped, err, fin;
	logic [shs_pkg::ROUND_W:0]   round_inc;
	logic [shs_pkg::PROD_W-1:0]  prod;
	logic [shs_pkg::LEFT_W-1:0]  left_dec;

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= shs_pkg::MODE_IDLE;
			phase_q      <= shs_pkg::PH_SEEK_LOW;
			round_q      <= '0;
			quot_q       <= '0;
			rem_q        <= '0;
			rev_q        <= '0;
			coil_phase_q <= '0;
			left_q       <= '0;
			coil_q       <= '0;
		end else if (go) begin
			mode_q       <= mode_d;
			phase_q      <= phase_d;
			round_q      <= round_d;
			quot_q       <= quot_d;
			rem_q        <= rem_d;
			rev_q        <= rev_d;
			coil_phase_q <= coil_phase_d;
			left_q       <= left_d;
			coil_q       <= coil_d;
		end
	end

	assign round_inc = {1'b0, round_q} + {{shs_pkg::ROUND_W{1'b0}}, 1'b1};
	assign prod      = rev_q * item.run_eighths;
	assign left_dec  = (left_q != '0) ? left_q - 1'b1 : '0;

	// Next state for one item
	always_comb begin
		mode_d   = mode_q;
		phase_d  = phase_q;
		round_d  = round_q;
		rev_d    = rev_q;
		left_d   = left_q;
		step_en  = 1'b0;
		count_en = 1'b0;
		err      = 1'b0;
		fin      = 1'b0;
		case (shs_pkg::op_t'(item.op))
			shs_pkg::OP_TICK: begin
				case (mode_q)
					shs_pkg::MODE_CAL: begin
						// at most one phase hop per tick; each tick steps unless it ends calibration
						case (phase_q)
							shs_pkg::PH_SEEK_LOW: begin
								step_en = 1'b1;
								if (item.opto_level) begin
									phase_d = shs_pkg::PH_SEEK_HIGH;
								end
							end
							shs_pkg::PH_SEEK_HIGH: begin
								step_en = 1'b1;
								if (!item.opto_level) begin
									phase_d  = shs_pkg::PH_CNT_LOW;
									count_en = 1'b1;
								end
							end
							shs_pkg::PH_CNT_LOW: begin
								step_en  = 1'b1;
								count_en = 1'b1;
								if (item.opto_level) begin
									phase_d = shs_pkg::PH_CNT_HIGH;
								end
							end
							default: begin
								if (item.opto_level) begin
									step_en  = 1'b1;
									count_en = 1'b1;
								end else if (round_inc >= shs_pkg::CAL_ROUNDS_C) begin
									// last round done: store the average
									rev_d   = quot_q;
									mode_d  = shs_pkg::MODE_IDLE;
									phase_d = shs_pkg::PH_SEEK_LOW;
									round_d = '0;
									fin     = 1'b1;
								end else begin
									round_d  = round_inc[shs_pkg::ROUND_W-1:0];
									phase_d  = shs_pkg::PH_CNT_LOW;
									step_en  = 1'b1;
									count_en = 1'b1;
								end
							end
						endcase
					end
					shs_pkg::MODE_RUN: begin
						step_en = 1'b1;
						left_d  = left_dec;
						if (left_dec == '0) begin
							mode_d = shs_pkg::MODE_IDLE;
							fin    = 1'b1;
						end
					end
					default: begin
					end
				endcase
			end
			shs_pkg::OP_CAL: begin
				if (mode_q == shs_pkg::MODE_IDLE) begin
					mode_d  = shs_pkg::MODE_CAL;
					phase_d = shs_pkg::PH_SEEK_LOW;
					round_d = '0;
					rev_d   = '0;
				end
			end
			shs_pkg::OP_RUN: begin
				if (mode_q == shs_pkg::MODE_IDLE) begin
					if (rev_q == '0) begin
						err = 1'b1;
					end else begin
						left_d = prod[shs_pkg::PROD_W-1:3];
						if (prod[shs_pkg::PROD_W-1:3] == '0) begin
							fin = 1'b1;
						end else begin
							mode_d = shs_pkg::MODE_RUN;
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Tally: cleared on calibration start, saturates at the top quotient
	always_comb begin
		quot_d = quot_q;
		rem_d  = rem_q;
		if (shs_pkg::op_t'(item.op) == shs_pkg::OP_CAL && mode_q == shs_pkg::MODE_IDLE) begin
			quot_d = '0;
			rem_d  = '0;
		end else if (count_en && quot_q != shs_pkg::REV_MAX) begin
			if (rem_q == shs_pkg::CAL_LAST) begin
				rem_d  = '0;
				quot_d = quot_q + 1'b1;
			end else begin
				rem_d = rem_q + 1'b1;
			end
		end
	end

	// Coil sequencer
	always_comb begin
		coil_d       = coil_q;
		coil_phase_d = coil_phase_q;
		if (step_en) begin
			coil_d       = shs_pkg::half_step(coil_phase_q);
			coil_phase_d = coil_phase_q + 1'b1;
		end
	end

	assign stepped = step_en;

	always_comb begin
		result.coils                = coil_d;
		result.stepped              = stepped;
		result.mode                 = mode_d;
		result.steps_per_rev        = rev_d;
		result.calibrated           = (rev_d != '0);
		result.not_calibrated_error = err;
		result.finished             = fin;
	end

endmodule

// File: verif/stepper_drive_checker.sv
module stepper_drive_checker (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	input  logic          cmd_ready,
	input  shs_pkg::cmd_t cmd,
	input  logic          res_valid,
	input  logic          res_ready,
	input  shs_pkg::res_t res,
	output int            fault_count,
	output int            results_owed
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned TALLY_MAX = 65535 * shs_pkg::CAL_ROUNDS;
	localparam int unsigned TALLY_W   = $clog2(TALLY_MAX + 1);
	// half-step patterns, entry 0 in the low nibble
	localparam logic [31:0] HALF_SEQ = {4'd9, 4'd8, 4'd12, 4'd4, 4'd6, 4'd2, 4'd3, 4'd1};

	// own copy of the driver state
	shs_pkg::mode_t              drv_mode;
	shs_pkg::cal_phase_t         cal_step;
	logic [shs_pkg::ROUND_W-1:0] rounds_done;
	logic [TALLY_W-1:0]          tally;
	logic [shs_pkg::REV_W-1:0]   rev;
	logic [2:0]                  seq_idx;
	logic [shs_pkg::LEFT_W-1:0]  left;
	logic [3:0]                  latch;

	shs_pkg::res_t drive_results_due[$];
	shs_pkg::res_t want;

	function automatic void drive_next_pattern();
		latch   = HALF_SEQ[{seq_idx, 2'b00} +: 4];
		seq_idx = seq_idx + 3'd1;
	endfunction

	// works out the result of one item and moves the state on
	function automatic shs_pkg::res_t predict_drive(input shs_pkg::cmd_t c);
		shs_pkg::res_t              r;
		logic                       moved;
		logic                       fault;
		logic                       fin;
		logic                       settled;
		logic [shs_pkg::PROD_W-1:0] product;
		moved = 1'b0;
		fault = 1'b0;
		fin   = 1'b0;
		case (c.op)
			shs_pkg::OP_TICK: begin
				if (drv_mode == shs_pkg::MODE_CAL) begin
					// a failed phase test moves on and tests the same level again
					settled = 1'b0;
					while (!settled) begin
						case (cal_step)
							shs_pkg::PH_SEEK_LOW: begin
								if (!c.opto_level) begin
									drive_next_pattern();
									moved   = 1'b1;
									settled = 1'b1;
								end else
									cal_step = shs_pkg::PH_SEEK_HIGH;
							end
							shs_pkg::PH_SEEK_HIGH: begin
								if (c.opto_level) begin
									drive_next_pattern();
									moved   = 1'b1;
									settled = 1'b1;
								end else
									cal_step = shs_pkg::PH_CNT_LOW;
							end
							shs_pkg::PH_CNT_LOW: begin
								if (!c.opto_level) begin
									drive_next_pattern();
									if (tally < TALLY_MAX)
										tally = tally + 1'b1;
									moved   = 1'b1;
									settled = 1'b1;
								end else
									cal_step = shs_pkg::PH_CNT_HIGH;
							end
							default: begin
								if (c.opto_level) begin
									drive_next_pattern();
									if (tally < TALLY_MAX)
										tally = tally + 1'b1;
									moved   = 1'b1;
									settled = 1'b1;
								end else begin
									rounds_done = rounds_done + 1'b1;
									if (rounds_done >= shs_pkg::CAL_ROUNDS) begin
										rev         = shs_pkg::REV_W'(tally / shs_pkg::CAL_ROUNDS);
										drv_mode    = shs_pkg::MODE_IDLE;
										cal_step    = shs_pkg::PH_SEEK_LOW;
										rounds_done = '0;
										fin         = 1'b1;
										settled     = 1'b1;
									end else
										cal_step = shs_pkg::PH_CNT_LOW;
								end
							end
						endcase
					end
				end else if (drv_mode == shs_pkg::MODE_RUN) begin
					drive_next_pattern();
					moved = 1'b1;
					if (left != 0)
						left = left - 1'b1;
					if (left == 0) begin
						drv_mode = shs_pkg::MODE_IDLE;
						fin      = 1'b1;
					end
				end
			end
			shs_pkg::OP_CAL: begin
				if (drv_mode == shs_pkg::MODE_IDLE) begin
					drv_mode    = shs_pkg::MODE_CAL;
					cal_step    = shs_pkg::PH_SEEK_LOW;
					rounds_done = '0;
					tally       = '0;
					rev         = '0;
				end
			end
			shs_pkg::OP_RUN: begin
				if (drv_mode == shs_pkg::MODE_IDLE) begin
					if (rev == 0)
						fault = 1'b1;
					else begin
						product = shs_pkg::PROD_W'(rev) * shs_pkg::PROD_W'(c.run_eighths);
						left    = shs_pkg::LEFT_W'(product >> 3);
						if (left == 0)
							fin = 1'b1;
						else
							drv_mode = shs_pkg::MODE_RUN;
					end
				end
			end
			default: ;
		endcase
		r.coils                = latch;
		r.stepped              = moved;
		r.mode                 = drv_mode;
		r.steps_per_rev        = rev;
		r.calibrated           = (rev != 0);
		r.not_calibrated_error = fault;
		r.finished             = fin;
		return r;
	endfunction

	task automatic compare_field(input string field, input int unsigned exp_val,
			input int unsigned got_val);
		if (exp_val != got_val) begin
			$error("%s: expected %0d, got %0d", field, exp_val, got_val);
			fault_count++;
		end
	endtask

	// compare results in order, then queue the prediction for a new item
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drv_mode    = shs_pkg::MODE_IDLE;
			cal_step    = shs_pkg::PH_SEEK_LOW;
			rounds_done = '0;
			tally       = '0;
			rev         = '0;
			seq_idx     = '0;
			left        = '0;
			latch       = '0;
			drive_results_due.delete();
			results_owed <= 0;
		end else begin
			if (res_valid && res_ready) begin
				if (drive_results_due.size() == 0) begin
					$error("result item arrived with none outstanding");
					fault_count++;
				end else begin
					want = drive_results_due.pop_front();
					compare_field("coils", want.coils, res.coils);
					compare_field("stepped", want.stepped, res.stepped);
					compare_field("mode", want.mode, res.mode);
					compare_field("steps_per_rev", want.steps_per_rev, res.steps_per_rev);
					compare_field("calibrated", want.calibrated, res.calibrated);
					compare_field("not_calibrated_error", want.not_calibrated_error,
						res.not_calibrated_error);
					compare_field("finished", want.finished, res.finished);
				end
			end
			if (cmd_valid && cmd_ready)
				drive_results_due.push_back(predict_drive(cmd));
			results_owed <= drive_results_due.size();
		end
	end

endmodule

// File: verif/stepper_half_step_calibrated_run_tb.sv
module stepper_half_step_calibrated_run_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] OP_SPARE = 2'd3;

	logic          clk       = 1'b0;
	logic          arst_n    = 1'b0;
	logic          cmd_valid = 1'b0;
	logic          cmd_ready;
	shs_pkg::cmd_t cmd       = '0;
	logic          res_valid;
	logic          res_ready = 1'b0;
	shs_pkg::res_t res;

	int fault_count;
	int results_owed;
	int sender_idle_pct   = 0;
	int receiver_idle_pct = 0;
	int items_sent        = 0;
	int ends_seen         = 0;

	always #2 clk = ~clk;

	stepper_half_step_calibrated_run DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	stepper_drive_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd_ready    (cmd_ready),
		.cmd          (cmd),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.res          (res),
		.fault_count  (fault_count),
		.results_owed (results_owed)
	);

	// receiver stalls at random
	always @(posedge clk) begin
		res_ready <= ($urandom_range(99, 0) >= receiver_idle_pct);
	end

	// count finished or rejected operations so sequences know when to stop ticking
	always @(posedge clk) begin
		if (res_valid && res_ready && (res.finished || res.not_calibrated_error))
			ends_seen <= ends_seen + 1;
	end

	task automatic send_item(input logic [1:0] op, input logic lvl, input logic [15:0] eighths);
		shs_pkg::cmd_t item;
		item.op          = op;
		item.opto_level  = lvl;
		item.run_eighths = eighths;
		if ($urandom_range(99, 0) < sender_idle_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99, 0) < sender_idle_pct)
				@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd       <= item;
		@(posedge clk);
		while (!cmd_ready)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic tick(input logic lvl);
		send_item(shs_pkg::OP_TICK, lvl, 16'($urandom));
	endtask

	// random-level ticks until the operation under way reports its end
	task automatic finish_sequence(input int mark);
		while (ends_seen == mark)
			tick(1'($urandom_range(1, 0)));
	endtask

	task automatic send_noise();
		case ($urandom_range(3, 0))
			0: send_item(shs_pkg::OP_CAL, 1'($urandom_range(1, 0)), 16'($urandom));
			1: send_item(shs_pkg::OP_RUN, 1'($urandom_range(1, 0)), 16'($urandom_range(40, 0)));
			2: send_item(OP_SPARE, 1'($urandom_range(1, 0)), 16'($urandom));
			default: tick(1'($urandom_range(1, 0)));
		endcase
	endtask

	// well-formed slot pattern with random half lengths and the odd stray item
	task automatic calibration_seq(input int max_half);
		int mark;
		mark = ends_seen;
		send_item(shs_pkg::OP_CAL, 1'($urandom_range(1, 0)), 16'($urandom));
		repeat ($urandom_range(3, 0)) tick(1'b0);
		repeat ($urandom_range(3, 1)) tick(1'b1);
		for (int r = 0; r < shs_pkg::CAL_ROUNDS; r++) begin
			repeat ($urandom_range(max_half, 1)) begin
				tick(1'b0);
				if ($urandom_range(99, 0) < 15)
					send_noise();
			end
			repeat ($urandom_range(max_half, 1)) tick(1'b1);
		end
		tick(1'b0);
		finish_sequence(mark);
	endtask

	task automatic run_seq(input int max_eighths);
		int mark;
		mark = ends_seen;
		send_item(shs_pkg::OP_RUN, 1'($urandom_range(1, 0)),
			16'($urandom_range(max_eighths, 0)));
		if ($urandom_range(9, 0) == 0)
			send_noise();
		finish_sequence(mark);
	endtask

	task automatic random_until(input int target);
		int pick;
		int mark;
		while (items_sent < target) begin
			pick = $urandom_range(99, 0);
			if (pick < 45)
				calibration_seq($urandom_range(12, 1));
			else if (pick < 80)
				run_seq((pick < 70) ? 40 : 80);
			else if (pick < 90) begin
				// calibration fed with random levels
				mark = ends_seen;
				send_item(shs_pkg::OP_CAL, 1'($urandom_range(1, 0)), 16'($urandom));
				finish_sequence(mark);
			end else begin
				repeat ($urandom_range(4, 1)) begin
					if ($urandom_range(1, 0))
						tick(1'($urandom_range(1, 0)));
					else
						send_item(OP_SPARE, 1'($urandom_range(1, 0)), 16'($urandom));
				end
			end
		end
	endtask

	// hold off the sender until every outstanding result has come back
	task automatic wait_results_settled();
		cmd_valid <= 1'b0;
		@(posedge clk);
		while (results_owed != 0)
			@(posedge clk);
	endtask

	initial begin
		int mark;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed: spare op, idle tick, run while uncalibrated
		send_item(OP_SPARE, 1'b1, 16'hFFFF);
		tick(1'b1);
		send_item(shs_pkg::OP_RUN, 1'b0, 16'd8);
		// shortest calibration, with commands arriving while busy
		send_item(shs_pkg::OP_CAL, 1'b1, 16'h0000);
		tick(1'b0);
		tick(1'b1);
		send_item(shs_pkg::OP_RUN, 1'b1, 16'hFFFF);
		send_item(shs_pkg::OP_CAL, 1'b0, 16'hFFFF);
		repeat (shs_pkg::CAL_ROUNDS) begin
			tick(1'b0);
			tick(1'b1);
		end
		tick(1'b0);
		// zero-length runs, then a short run with a command while running
		send_item(shs_pkg::OP_RUN, 1'b0, 16'd0);
		send_item(shs_pkg::OP_RUN, 1'b0, 16'd1);
		send_item(shs_pkg::OP_RUN, 1'b1, 16'd12);
		send_item(shs_pkg::OP_CAL, 1'b1, 16'd0);
		tick(1'b0);
		tick(1'b1);
		tick(1'b0);
		tick(1'b1);
		// calibration that starts on a high level
		mark = ends_seen;
		send_item(shs_pkg::OP_CAL, 1'b0, 16'h5555);
		tick(1'b1);
		finish_sequence(mark);

		sender_idle_pct   = 29;
		receiver_idle_pct = 72;
		random_until(items_sent + 300);
		wait_results_settled();

		sender_idle_pct   = 72;
		receiver_idle_pct = 29;
		random_until(items_sent + 300);
		wait_results_settled();

		sender_idle_pct   = 0;
		receiver_idle_pct = 0;
		random_until(items_sent + 300);

		// largest run length; only its first steps are taken
		send_item(shs_pkg::OP_RUN, 1'b1, 16'hFFFF);
		repeat (20) begin
			tick(1'($urandom_range(1, 0)));
			if ($urandom_range(3, 0) == 0)
				send_noise();
		end

		wait_results_settled();
		repeat (8) @(posedge clk);
		if (fault_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// watchdog
	initial begin
		#10_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

// File: filelist.f
rtl/shs_pkg.sv
rtl/shs_ctrl.sv
rtl/stepper_half_step_calibrated_run.sv
verif/stepper_drive_checker.sv
verif/stepper_half_step_calibrated_run_tb.sv
